// ===== design/assert_macros.svh =====
// Assertion macros shared by the light-gun responder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/gbcr_pkg.sv =====
// Package for the light-gun board command responder: beat types, command codes,
// reply kinds and the reply byte selector. No dependencies.
`default_nettype none

package gbcr_pkg;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [7:0] OP_NONE      = 8'h00;
   localparam logic [7:0] OP_VERSION   = 8'h04;
   localparam logic [7:0] OP_GUN       = 8'h08;
   localparam logic [7:0] OP_NULL      = 8'h0C;
   localparam logic [7:0] OP_DIP       = 8'h10;
   localparam logic [7:0] OP_FREQ1     = 8'h14;
   localparam logic [7:0] OP_FREQ2     = 8'h18;
   localparam logic [7:0] OP_FREQ3     = 8'h19;
   localparam logic [7:0] OP_FREQ4     = 8'h1A;
   localparam logic [7:0] OP_LED       = 8'h1C;

   localparam logic [7:0] REPLY_UNKNOWN = 8'h01;
   localparam logic [7:0] REPLY_FILL    = 8'h75;
   localparam logic [7:0] REPLY_ONES    = 8'hFF;
   localparam logic [7:0] SUM_INIT      = 8'hFF;

   localparam logic [7:0] DIP_FREQ1 = 8'h80;
   localparam logic [7:0] DIP_FREQ2 = 8'h40;
   localparam logic [7:0] DIP_FREQ3 = 8'h20;
   localparam logic [7:0] DIP_FREQ4 = 8'h10;

   localparam logic [2:0] FREQ_NONE = 3'd0;
   localparam logic [2:0] FREQ_1    = 3'd1;
   localparam logic [2:0] FREQ_2    = 3'd2;
   localparam logic [2:0] FREQ_3    = 3'd3;
   localparam logic [2:0] FREQ_4    = 3'd4;

   localparam logic [7:0] LEN_MIN  = 8'd2;
   localparam logic [7:0] LEN_GUN  = 8'd12;
   localparam logic [7:0] LEN_LED  = 8'd11;

   localparam logic [3:0] COUNT_SINGLE = 4'd1;
   localparam logic [3:0] COUNT_GUN    = 4'd11;
   localparam logic [3:0] COUNT_LED    = 4'd10;

   localparam logic [1:0] REG_VERSION = 2'd0;
   localparam logic [1:0] REG_WIDTH   = 2'd1;
   localparam logic [1:0] REG_HEIGHT  = 2'd2;

   localparam logic [15:0] SPAN_RESET = 16'd1024;
   localparam logic [10:0] Y_FULL     = 11'd1024;
   localparam int          FRAC_BITS  = 10;
   localparam int          DVD_BITS   = 16 + FRAC_BITS;
   localparam logic [4:0]  STEP_LAST  = 5'(DVD_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_GUN    = 2'd1,
      KIND_LED    = 2'd2
   } kind_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  command_byte;
      logic [7:0]  transfer_length;
      logic [15:0] pointer_x;
      logic [15:0] pointer_y;
   } req_type;

   typedef struct packed {
      logic [7:0] response_byte;
      logic       last_byte;
   } rsp_type;

   function automatic logic [7:0] reply_byte(kind_type kind, logic [3:0] idx,
                                             logic [7:0] single, logic [9:0] x,
                                             logic [10:0] y);
      logic [7:0] b;
      b = 8'h00;
      case (kind)
         KIND_SINGLE: b = single;
         KIND_LED:    b = REPLY_ONES;
         KIND_GUN: begin
            case (idx)
               4'd1:    b = {6'b0, x[9:8]};
               4'd2:    b = x[7:0];
               4'd3:    b = {5'b0, y[10:8]};
               4'd4:    b = y[7:0];
               4'd8, 4'd9, 4'd10: b = REPLY_FILL;
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== design/gun_board_command_responder.sv =====
// Light-gun board command responder: a write returns no beat; single-byte
// reads are accepted then give 2 beats; gun reads run the shared restoring
// divider (26 steps each for x and y) then give 12 beats; LED reads 11 beats.
// One beat per cycle while rsp_ready holds; next item accepted once the checksum
// beat is loaded. Synchronous active-high reset: control and CSR registers at defaults, no command.
`default_nettype none
`include "assert_macros.svh"

module gun_board_command_responder (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire gbcr_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output gbcr_pkg::rsp_type    rsp_payload,
   input  wire                  csr_write_enable,
   input  wire  [1:0]           csr_index,
   input  wire  [15:0]          csr_write_data
);

   gbcr_pkg::state_type state_ff, state_in;
   gbcr_pkg::kind_type  kind_ff, kind_in;
   logic [7:0]  version_ff, version_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  pending_ff, pending_in;
   logic [2:0]  freq_ff, freq_in;
   logic [7:0]  single_ff, single_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] ypos_ff, ypos_in;
   logic [25:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  step_ff, step_in;
   logic        phase_ff, phase_in;
   logic [9:0]  x_ff, x_in;
   logic [10:0] y_ff, y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gbcr_pkg::rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic [15:0] divisor;
   logic [16:0] shifted;
   logic [16:0] diff;
   logic        qbit;
   logic [9:0]  quot;
   logic        load;
   logic [7:0]  beat_byte;
   logic [7:0]  dip;
   logic        in_div;
   logic        div_end;

   assign req_ready   = (state_ff == gbcr_pkg::ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // shared divider step
   assign divisor = phase_ff ? height_ff : width_ff;
   assign shifted = {rem_ff, dvd_ff[25]};
   assign diff    = shifted - {1'b0, divisor};
   assign qbit    = (shifted >= {1'b0, divisor});
   assign quot    = (divisor == 16'd0) ? 10'd0 : {dvd_ff[8:0], qbit};
   assign in_div  = (state_ff == gbcr_pkg::ST_DIV);
   assign div_end = in_div && phase_ff && (step_ff == gbcr_pkg::STEP_LAST);

   assign load      = (state_ff == gbcr_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign beat_byte = gbcr_pkg::reply_byte(kind_ff, idx_ff, single_ff, x_ff, y_ff);

   always_comb begin
      case (freq_ff)
         gbcr_pkg::FREQ_1: dip = gbcr_pkg::DIP_FREQ1;
         gbcr_pkg::FREQ_2: dip = gbcr_pkg::DIP_FREQ2;
         gbcr_pkg::FREQ_3: dip = gbcr_pkg::DIP_FREQ3;
         gbcr_pkg::FREQ_4: dip = gbcr_pkg::DIP_FREQ4;
         default:          dip = 8'h00;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      version_in   = version_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pending_in   = pending_ff;
      freq_in      = freq_ff;
      single_in    = single_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      ypos_in      = ypos_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_write_enable) begin
         case (csr_index)
            gbcr_pkg::REG_VERSION: version_in = csr_write_data[7:0];
            gbcr_pkg::REG_WIDTH:   width_in   = csr_write_data;
            gbcr_pkg::REG_HEIGHT:  height_in  = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         gbcr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_payload.cmd == gbcr_pkg::CMD_WRITE) begin
                  if (req_payload.transfer_length != 8'd0) begin
                     pending_in = req_payload.command_byte;
                  end
               end else if (pending_ff != gbcr_pkg::OP_NONE &&
                            req_payload.transfer_length >= gbcr_pkg::LEN_MIN) begin
                  idx_in    = 4'd0;
                  sum_in    = gbcr_pkg::SUM_INIT;
                  kind_in   = gbcr_pkg::KIND_SINGLE;
                  count_in  = gbcr_pkg::COUNT_SINGLE;
                  single_in = 8'h00;
                  case (pending_ff)
                     gbcr_pkg::OP_GUN: begin
                        if (req_payload.transfer_length >= gbcr_pkg::LEN_GUN) begin
                           kind_in    = gbcr_pkg::KIND_GUN;
                           count_in   = gbcr_pkg::COUNT_GUN;
                           dvd_in     = {req_payload.pointer_x, 10'b0};
                           rem_in     = 16'd0;
                           step_in    = 5'd0;
                           phase_in   = 1'b0;
                           ypos_in    = req_payload.pointer_y;
                           pending_in = gbcr_pkg::OP_NONE;
                           state_in   = gbcr_pkg::ST_DIV;
                        end
                     end
                     gbcr_pkg::OP_LED: begin
                        if (req_payload.transfer_length >= gbcr_pkg::LEN_LED) begin
                           kind_in    = gbcr_pkg::KIND_LED;
                           count_in   = gbcr_pkg::COUNT_LED;
                           pending_in = gbcr_pkg::OP_NONE;
                           state_in   = gbcr_pkg::ST_EMIT;
                        end
                     end
                     default: begin
                        case (pending_ff)
                           gbcr_pkg::OP_VERSION: single_in = version_ff;
                           gbcr_pkg::OP_NULL:    single_in = 8'h00;
                           gbcr_pkg::OP_DIP:     single_in = dip;
                           gbcr_pkg::OP_FREQ1:   freq_in   = gbcr_pkg::FREQ_1;
                           gbcr_pkg::OP_FREQ2:   freq_in   = gbcr_pkg::FREQ_2;
                           gbcr_pkg::OP_FREQ3:   freq_in   = gbcr_pkg::FREQ_3;
                           gbcr_pkg::OP_FREQ4:   freq_in   = gbcr_pkg::FREQ_4;
                           default:              single_in = gbcr_pkg::REPLY_UNKNOWN;
                        endcase
                        pending_in = gbcr_pkg::OP_NONE;
                        state_in   = gbcr_pkg::ST_EMIT;
                     end
                  endcase
               end
            end
         end
         gbcr_pkg::ST_DIV: begin
            rem_in  = qbit ? diff[15:0] : shifted[15:0];
            dvd_in  = {dvd_ff[24:0], qbit};
            step_in = step_ff + 5'd1;
            if (step_ff == gbcr_pkg::STEP_LAST) begin
               step_in = 5'd0;
               rem_in  = 16'd0;
               if (!phase_ff) begin
                  x_in     = quot;
                  dvd_in   = {ypos_ff, 10'b0};
                  phase_in = 1'b1;
               end else begin
                  y_in     = gbcr_pkg::Y_FULL - {1'b0, quot};
                  state_in = gbcr_pkg::ST_EMIT;
               end
            end
         end
         gbcr_pkg::ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (idx_ff == count_ff) begin
                  rsp_in   = '{response_byte: sum_ff, last_byte: 1'b1};
                  state_in = gbcr_pkg::ST_IDLE;
               end else begin
                  rsp_in = '{response_byte: beat_byte, last_byte: 1'b0};
                  sum_in = sum_ff - beat_byte;
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         default: state_in = gbcr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbcr_pkg::ST_IDLE;
         version_ff   <= 8'h00;
         width_ff     <= gbcr_pkg::SPAN_RESET;
         height_ff    <= gbcr_pkg::SPAN_RESET;
         pending_ff   <= gbcr_pkg::OP_NONE;
         freq_ff      <= gbcr_pkg::FREQ_NONE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
         step_ff      <= 5'd0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         version_ff   <= version_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pending_ff   <= pending_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      single_ff <= single_in;
      count_ff  <= count_in;
      sum_ff    <= sum_in;
      ypos_ff   <= ypos_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      rsp_ff    <= rsp_in;
   end

   `ASSERT_IMPLIES(a_emit_idx, clock, reset, state_ff == gbcr_pkg::ST_EMIT, idx_ff <= count_ff)
   `ASSERT_NEXT(a_no_cmd_idle, clock, reset, accept && pending_ff == gbcr_pkg::OP_NONE, req_ready)
   `ASSERT_NEXT(a_div_done, clock, reset, div_end, state_ff == gbcr_pkg::ST_EMIT)
   `ASSERT_IMPLIES(a_div_kind, clock, reset, in_div, kind_ff == gbcr_pkg::KIND_GUN)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the light-gun board command responder: directed and random
// write/read transfers, register phases and a reply-side predictor. Depends on gbcr_pkg.

module testbench;

   class reply_scoreboard;
      logic [7:0]  version;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  command;
      logic [2:0]  freq;
      gbcr_pkg::rsp_type bytes_due[$];
      int          errors;

      function new();
         version = 8'h00;
         width   = gbcr_pkg::SPAN_RESET;
         height  = gbcr_pkg::SPAN_RESET;
         command = gbcr_pkg::OP_NONE;
         freq    = gbcr_pkg::FREQ_NONE;
         errors  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            gbcr_pkg::REG_VERSION: version = data[7:0];
            gbcr_pkg::REG_WIDTH:   width = data;
            gbcr_pkg::REG_HEIGHT:  height = data;
            default: ;
         endcase
      endfunction

      function logic [9:0] scale(logic [15:0] pos, logic [15:0] span);
         logic [31:0] q;
         q = 32'd0;
         if (span != 16'd0) q = ({16'd0, pos} << gbcr_pkg::FRAC_BITS) / {16'd0, span};
         return q[9:0];
      endfunction

      function void note_transfer(gbcr_pkg::req_type r);
         logic [7:0]  body[$];
         logic [9:0]  x;
         logic [10:0] y;
         logic [7:0]  sum;
         gbcr_pkg::rsp_type b;
         if (r.cmd == gbcr_pkg::CMD_WRITE) begin
            if (r.transfer_length != 8'd0) command = r.command_byte;
            return;
         end
         if (command == gbcr_pkg::OP_NONE || r.transfer_length < gbcr_pkg::LEN_MIN) return;
         case (command)
            gbcr_pkg::OP_VERSION: body.push_back(version);
            gbcr_pkg::OP_GUN: begin
               if (r.transfer_length < gbcr_pkg::LEN_GUN) return;
               x = scale(r.pointer_x, width);
               y = gbcr_pkg::Y_FULL - {1'b0, scale(r.pointer_y, height)};
               body.push_back(8'h00);
               body.push_back({6'b0, x[9:8]});
               body.push_back(x[7:0]);
               body.push_back({5'b0, y[10:8]});
               body.push_back(y[7:0]);
               repeat (3) body.push_back(8'h00);
               repeat (3) body.push_back(gbcr_pkg::REPLY_FILL);
            end
            gbcr_pkg::OP_NULL: body.push_back(8'h00);
            gbcr_pkg::OP_DIP: begin
               case (freq)
                  gbcr_pkg::FREQ_1: body.push_back(gbcr_pkg::DIP_FREQ1);
                  gbcr_pkg::FREQ_2: body.push_back(gbcr_pkg::DIP_FREQ2);
                  gbcr_pkg::FREQ_3: body.push_back(gbcr_pkg::DIP_FREQ3);
                  gbcr_pkg::FREQ_4: body.push_back(gbcr_pkg::DIP_FREQ4);
                  default:          body.push_back(8'h00);
               endcase
            end
            gbcr_pkg::OP_FREQ1: begin
               freq = gbcr_pkg::FREQ_1;
               body.push_back(8'h00);
            end
            gbcr_pkg::OP_FREQ2: begin
               freq = gbcr_pkg::FREQ_2;
               body.push_back(8'h00);
            end
            gbcr_pkg::OP_FREQ3: begin
               freq = gbcr_pkg::FREQ_3;
               body.push_back(8'h00);
            end
            gbcr_pkg::OP_FREQ4: begin
               freq = gbcr_pkg::FREQ_4;
               body.push_back(8'h00);
            end
            gbcr_pkg::OP_LED: begin
               if (r.transfer_length < gbcr_pkg::LEN_LED) return;
               repeat (10) body.push_back(gbcr_pkg::REPLY_ONES);
            end
            default: body.push_back(gbcr_pkg::REPLY_UNKNOWN);
         endcase
         command = gbcr_pkg::OP_NONE;
         sum = gbcr_pkg::SUM_INIT;
         foreach (body[i]) begin
            sum = sum - body[i];
            b.response_byte = body[i];
            b.last_byte = 1'b0;
            bytes_due.push_back(b);
         end
         b.response_byte = sum;
         b.last_byte = 1'b1;
         bytes_due.push_back(b);
      endfunction

      function void check_beat(gbcr_pkg::rsp_type got);
         gbcr_pkg::rsp_type want;
         if (bytes_due.size() == 0) begin
            $error("unexpected reply beat: response_byte %h last_byte %b",
                   got.response_byte, got.last_byte);
            errors++;
            return;
         end
         want = bytes_due.pop_front();
         if (got.response_byte !== want.response_byte) begin
            $error("response_byte: expected %h, actual %h", want.response_byte,
                   got.response_byte);
            errors++;
         end
         if (got.last_byte !== want.last_byte) begin
            $error("last_byte: expected %b, actual %b", want.last_byte, got.last_byte);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   gbcr_pkg::req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   gbcr_pkg::rsp_type rsp_payload;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   bit              steady;
   bit              hold_replies;
   reply_scoreboard sb;

   logic [7:0] op_list [10] = '{gbcr_pkg::OP_VERSION, gbcr_pkg::OP_GUN, gbcr_pkg::OP_NULL,
                                gbcr_pkg::OP_DIP, gbcr_pkg::OP_FREQ1, gbcr_pkg::OP_FREQ2,
                                gbcr_pkg::OP_FREQ3, gbcr_pkg::OP_FREQ4, gbcr_pkg::OP_LED,
                                gbcr_pkg::OP_NONE};

   gun_board_command_responder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_transfer(req_payload);
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_payload);
      end
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic gbcr_pkg::req_type write_item(logic [7:0] op, logic [7:0] len);
      gbcr_pkg::req_type r;
      r.cmd = gbcr_pkg::CMD_WRITE;
      r.command_byte = op;
      r.transfer_length = len;
      r.pointer_x = 16'($urandom);
      r.pointer_y = 16'($urandom);
      return r;
   endfunction

   function automatic gbcr_pkg::req_type read_item(logic [7:0] len, logic [15:0] px,
                                                   logic [15:0] py);
      gbcr_pkg::req_type r;
      r.cmd = gbcr_pkg::CMD_READ;
      r.command_byte = 8'($urandom);
      r.transfer_length = len;
      r.pointer_x = px;
      r.pointer_y = py;
      return r;
   endfunction

   function automatic gbcr_pkg::req_type random_item();
      gbcr_pkg::req_type r;
      r.cmd = 1'($urandom);
      r.command_byte = 8'($urandom);
      r.transfer_length = 8'($urandom);
      r.pointer_x = 16'($urandom);
      r.pointer_y = 16'($urandom);
      return r;
   endfunction

   // hold valid and payload until the beat is taken
   task automatic send_item(input gbcr_pkg::req_type r);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_random(input int count);
      int         sent;
      int         kind;
      logic [7:0] op;
      logic [7:0] need;
      logic [7:0] len;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            send_item(random_item());
            sent++;
         end else begin
            if (kind < 20) op = 8'($urandom);
            else op = op_list[$urandom_range(0, 9)];
            send_item(write_item(op, (kind < 23) ? 8'd0 : 8'($urandom_range(1, 255))));
            need = (op == gbcr_pkg::OP_GUN) ? gbcr_pkg::LEN_GUN :
                   (op == gbcr_pkg::OP_LED) ? gbcr_pkg::LEN_LED : gbcr_pkg::LEN_MIN;
            if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(0, need - 1));
            else len = 8'($urandom_range(need, 255));
            send_item(read_item(len, 16'($urandom), 16'($urandom)));
            sent += 2;
         end
      end
   endtask

   // drop valid, drain the replies, let a trailing write or short read finish
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.bytes_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] v, input logic [15:0] w,
                               input logic [15:0] h);
      put_reg(gbcr_pkg::REG_VERSION, {8'h00, v});
      put_reg(gbcr_pkg::REG_WIDTH, w);
      put_reg(gbcr_pkg::REG_HEIGHT, h);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int n;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_replies) begin
            n = 400;
            hold_replies = 1'b0;
         end else begin
            n = idle_cycles();
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      #10_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      sb = new();
      steady = 1'b0;
      hold_replies = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= gbcr_pkg::REG_VERSION;
      csr_write_data <= 16'h0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(read_item(8'd255, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_VERSION, 8'd0));
      send_item(write_item(gbcr_pkg::OP_NONE, 8'd5));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_VERSION, 8'd1));
      send_item(read_item(8'd1, 16'($urandom), 16'($urandom)));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_GUN, 8'd255));
      send_item(read_item(8'd11, 16'hFFFF, 16'hFFFF));
      send_item(read_item(8'd12, 16'hFFFF, 16'hFFFF));
      send_item(write_item(gbcr_pkg::OP_GUN, 8'd1));
      send_item(read_item(8'd255, 16'h0000, 16'h0000));
      send_item(write_item(gbcr_pkg::OP_LED, 8'd3));
      send_item(read_item(8'd10, 16'($urandom), 16'($urandom)));
      send_item(read_item(8'd255, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_NULL, 8'd1));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_DIP, 8'd1));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_FREQ4, 8'd1));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));
      send_item(write_item(gbcr_pkg::OP_DIP, 8'd1));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));
      send_item(write_item(8'hFF, 8'd255));
      send_item(read_item(8'd2, 16'($urandom), 16'($urandom)));

      for (int p = 0; p < 5; p++) begin
         settle();
         case (p)
            0: program_regs(8'hFF, 16'd1, 16'd1);
            1: program_regs(8'($urandom), 16'hFFFF, 16'hFFFF);
            2: program_regs(8'h00, 16'd0, 16'd0);
            3: program_regs(8'($urandom), 16'd640, 16'd480);
            default: program_regs(8'($urandom), 16'($urandom_range(1, 65535)),
                                  16'($urandom_range(1, 65535)));
         endcase
         steady = (p == 2);
         hold_replies = (p == 1);
         run_random(21);
      end

      settle();
      if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
